FILE: hdl/ekct_pkg.sv
// Shared types and constants for the event key counter table.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package ekct_pkg;

  // Commands on the input word
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_DUMP   = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_COUNTED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_INVALID  = 3'd3;
  localparam logic [2:0] ST_DUMP     = 3'd4;

  localparam int SVC_W       = 16;
  localparam int MSG_W       = 8;
  localparam int COUNT_W     = 32;
  localparam int INDEX_W     = 5;
  localparam int MSG_ID_LSB  = 24;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic        command;
    logic [63:0] service_word;
    logic [31:0] message_word;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [INDEX_W-1:0] entry_index;
    logic [SVC_W-1:0]   entry_service;
    logic [MSG_W-1:0]   entry_message;
    logic [COUNT_W-1:0] entry_count;
    logic               last;
  } res_word_t;

  typedef enum logic [1:0] {
    KIND_RECORD,
    KIND_INVALID,
    KIND_DUMP
  } kind_t;

  // Classified word handed from the front to the back
  typedef struct packed {
    kind_t            kind;
    logic [SVC_W-1:0] service;
    logic [MSG_W-1:0] message;
  } desc_t;

  typedef struct packed {
    logic [SVC_W-1:0]   service;
    logic [MSG_W-1:0]   message;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_SCAN,
    ENG_EMIT,
    ENG_DUMP_READ,
    ENG_DUMP_DATA
  } eng_state_t;

endpackage

FILE: hdl/event_key_counter_table_top.sv
// Top level of the event key counter table.
// Depends on ekct_pkg, ekct_front, ekct_queue and ekct_engine.
//
// Usage: words arrive on cmd (cmd_valid / cmd_stall) and results leave on res
// (res_valid / res_stall); a word moves at a clock edge with valid high and
// stall low. A record word gives one result word; a dump word gives
// TABLE_ENTRIES result words in slot order, last set on the final one, and
// empties the table afterwards.
// Input words are classified on entry and parked in a two-word queue, so the
// input keeps moving while the table engine is busy or the output is stalled.
// A record scan reads the occupied slots one slot per cycle through the single
// read port of the table memory. A dump does one memory read per occupied slot
// and one output word per slot.
// A stalled output holds its word; the engine waits with its result and the
// queue fills, after which cmd_stall rises.
// Reset (synchronous, active high) empties the table at once by clearing the
// fill level, and empties the queue and the output register.
`timescale 1ns / 1ps

module event_key_counter_table_top #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  ekct_pkg::cmd_word_t cmd,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  output ekct_pkg::res_word_t res,
  output logic                res_valid,
  input  logic                res_stall
);
  import ekct_pkg::*;

  desc_t front_desc;
  desc_t head_desc;
  logic  push;
  logic  queue_full;
  logic  queue_not_empty;
  logic  pop;

  ekct_front u_front (
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .queue_full (queue_full),
    .push       (push),
    .desc       (front_desc)
  );

  ekct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (front_desc),
    .full      (queue_full),
    .pop       (pop),
    .head      (head_desc),
    .not_empty (queue_not_empty)
  );

  ekct_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .desc       (head_desc),
    .desc_valid (queue_not_empty),
    .desc_pop   (pop),
    .res        (res),
    .res_valid  (res_valid),
    .res_stall  (res_stall)
  );

endmodule

FILE: hdl/ekct_front.sv
// Front end: takes input words and classifies them into descriptors.
// Depends on ekct_pkg; feeds ekct_queue.
`timescale 1ns / 1ps

module ekct_front (
  input  ekct_pkg::cmd_word_t cmd,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  logic                queue_full,
  output logic                push,
  output ekct_pkg::desc_t     desc
);
  import ekct_pkg::*;

  logic             svc_ok;
  logic [MSG_W-1:0] msg_id;

  assign svc_ok = (cmd.service_word[63:SVC_W] == '0);
  assign msg_id = cmd.message_word[MSG_ID_LSB +: MSG_W];

  always_comb begin
    desc.service = cmd.service_word[SVC_W-1:0];
    desc.message = msg_id;
    priority if (cmd.command == CMD_DUMP) begin
      desc.kind = KIND_DUMP;
    end else if (svc_ok && (msg_id != '0)) begin
      desc.kind = KIND_RECORD;
    end else begin
      desc.kind = KIND_INVALID;
    end
  end

  assign cmd_stall = queue_full;
  assign push      = cmd_valid && !queue_full;

endmodule

FILE: hdl/ekct_queue.sv
// Short descriptor queue between the front end and the table engine.
// Depends on ekct_pkg.
`timescale 1ns / 1ps

module ekct_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ekct_pkg::desc_t push_desc,
  output logic            full,
  input  logic            pop,
  output ekct_pkg::desc_t head,
  output logic            not_empty
);
  import ekct_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  desc_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [LVL_W-1:0] level;
  logic             do_push;
  logic             do_pop;

  assign full      = (level == LVL_W'(QUEUE_DEPTH));
  assign not_empty = (level != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        level <= LVL_W'(level + 1'b1);
      end else if (do_pop && !do_push) begin
        level <= LVL_W'(level - 1'b1);
      end
    end
  end

endmodule

FILE: hdl/ekct_engine.sv
// Back end: key table memory, sequential scan, dump sweep and output register.
// Depends on ekct_pkg; takes descriptors from ekct_queue.
`timescale 1ns / 1ps

module ekct_engine #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  ekct_pkg::desc_t     desc,
  input  logic                desc_valid,
  output logic                desc_pop,
  output ekct_pkg::res_word_t res,
  output logic                res_valid,
  input  logic                res_stall
);
  import ekct_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Table storage, one write and one registered read port
  entry_t           mem [TABLE_ENTRIES];
  entry_t           rdata;
  logic             mem_we;
  logic             mem_re;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_wdata;

  eng_state_t       state, state_next;
  desc_t            cur, cur_next;
  logic [CNT_W-1:0] fill, fill_next;       // occupied entries form a prefix
  logic [CNT_W-1:0] rd_ptr, rd_ptr_next;
  logic [IDX_W-1:0] chk_idx, chk_idx_next; // index of the entry in rdata
  logic             rd_vld, rd_vld_next;
  res_word_t        pend, pend_next;
  res_word_t        res_next;
  logic             res_load;

  logic             out_free;
  logic             hit;
  logic             miss;
  logic             dump_last;
  entry_t           dump_entry;
  logic [COUNT_W-1:0] count_inc;

  assign out_free   = !res_valid || !res_stall;
  assign hit        = rd_vld && (rdata.service == cur.service) &&
                      (rdata.message == cur.message);
  assign miss       = !rd_vld && (rd_ptr == fill);
  assign dump_last  = (chk_idx == IDX_W'(TABLE_ENTRIES - 1));
  assign dump_entry = rd_vld ? rdata : '0;
  assign count_inc  = COUNT_W'(rdata.count + 1'b1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ENG_IDLE: begin
        if (desc_valid) begin
          unique case (desc.kind)
            KIND_DUMP:    state_next = ENG_DUMP_READ;
            KIND_RECORD:  state_next = ENG_SCAN;
            default:      state_next = ENG_EMIT;
          endcase
        end
      end
      ENG_SCAN: begin
        if (hit || miss) begin
          state_next = ENG_EMIT;
        end
      end
      ENG_EMIT: begin
        if (out_free) begin
          state_next = ENG_IDLE;
        end
      end
      ENG_DUMP_READ: state_next = ENG_DUMP_DATA;
      ENG_DUMP_DATA: begin
        if (out_free) begin
          state_next = dump_last ? ENG_IDLE : ENG_DUMP_READ;
        end
      end
      default: state_next = ENG_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    desc_pop     = 1'b0;
    cur_next     = cur;
    fill_next    = fill;
    rd_ptr_next  = rd_ptr;
    chk_idx_next = chk_idx;
    rd_vld_next  = rd_vld;
    pend_next    = pend;
    res_next     = res;
    res_load     = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = chk_idx;
    mem_raddr    = rd_ptr[IDX_W-1:0];
    mem_wdata    = '0;
    unique case (state)
      ENG_IDLE: begin
        desc_pop    = desc_valid;
        cur_next    = desc;
        rd_ptr_next = '0;
        rd_vld_next = 1'b0;
        pend_next   = '{status: ST_INVALID, entry_index: '0,
                        entry_service: desc.service, entry_message: desc.message,
                        entry_count: '0, last: 1'b1};
      end
      ENG_SCAN: begin
        priority if (hit) begin
          mem_we      = 1'b1;
          mem_waddr   = chk_idx;
          mem_wdata   = '{service: cur.service, message: cur.message, count: count_inc};
          rd_vld_next = 1'b0;
          pend_next   = '{status: ST_COUNTED, entry_index: INDEX_W'(chk_idx),
                          entry_service: cur.service, entry_message: cur.message,
                          entry_count: count_inc, last: 1'b1};
        end else if (miss) begin
          rd_vld_next = 1'b0;
          if (fill != CNT_W'(TABLE_ENTRIES)) begin
            mem_we    = 1'b1;
            mem_waddr = fill[IDX_W-1:0];
            mem_wdata = '{service: cur.service, message: cur.message, count: COUNT_W'(1)};
            fill_next = CNT_W'(fill + 1'b1);
            pend_next = '{status: ST_INSERTED, entry_index: INDEX_W'(fill),
                          entry_service: cur.service, entry_message: cur.message,
                          entry_count: COUNT_W'(1), last: 1'b1};
          end else begin
            pend_next = '{status: ST_FULL, entry_index: '0,
                          entry_service: cur.service, entry_message: cur.message,
                          entry_count: '0, last: 1'b1};
          end
        end else if (rd_ptr != fill) begin
          // one read in flight per cycle, compare works on the registered rdata
          mem_re       = 1'b1;
          chk_idx_next = rd_ptr[IDX_W-1:0];
          rd_ptr_next  = CNT_W'(rd_ptr + 1'b1);
          rd_vld_next  = 1'b1;
        end else begin
          rd_vld_next = 1'b0;
        end
      end
      ENG_EMIT: begin
        if (out_free) begin
          res_load = 1'b1;
          res_next = pend;
        end
      end
      ENG_DUMP_READ: begin
        // slots past the fill level read as zero
        mem_re       = (rd_ptr < fill);
        rd_vld_next  = (rd_ptr < fill);
        chk_idx_next = rd_ptr[IDX_W-1:0];
      end
      ENG_DUMP_DATA: begin
        if (out_free) begin
          res_load = 1'b1;
          res_next = '{status: ST_DUMP, entry_index: INDEX_W'(chk_idx),
                       entry_service: dump_entry.service,
                       entry_message: dump_entry.message,
                       entry_count: dump_entry.count, last: dump_last};
          if (dump_last) begin
            fill_next = '0;
          end else begin
            rd_ptr_next = CNT_W'(rd_ptr + 1'b1);
          end
        end
      end
      default: begin
        rd_vld_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ENG_IDLE;
      fill      <= '0;
      rd_vld    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      rd_vld <= rd_vld_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur     <= cur_next;
    rd_ptr  <= rd_ptr_next;
    chk_idx <= chk_idx_next;
    pend    <= pend_next;
    res     <= res_next;
  end

`ifndef ASSERT_OFF
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(TABLE_ENTRIES))
    else $error("fill level beyond table size");

  a_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ENG_SCAN))
    else $error("table written outside a record scan");

  a_dump_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ENG_DUMP_DATA && out_free && dump_last) |=>
      (fill == '0 && state == ENG_IDLE))
    else $error("table not cleared after final dump word");

  a_last_only_dump: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.last) |-> (res.status == ST_DUMP))
    else $error("non-final word outside a dump");
`endif

endmodule

FILE: test/tb_event_key_counter_table_top.sv
// Self-checking testbench for event_key_counter_table_top: record and dump words
// against a shadow of the key table. Depends on ekct_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module tb_event_key_counter_table_top;
  import ekct_pkg::*;

  localparam int SLOTS       = 32;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 150;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  cmd_word_t cmd       = '0;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  res_word_t res;
  logic      res_valid;
  logic      res_stall = 1'b0;

  // Shadow of the key table
  logic [SVC_W-1:0]   shadow_service [SLOTS];
  logic [MSG_W-1:0]   shadow_message [SLOTS];
  logic [COUNT_W-1:0] shadow_count   [SLOTS];

  res_word_t pending_results[$];
  int        fail_count  = 0;
  int        idle_cycles = 0;
  int        stall_hold  = 0;
  bit        burst_mode  = 1'b0;

  event_key_counter_table_top #(
    .TABLE_ENTRIES(SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .res      (res),
    .res_valid(res_valid),
    .res_stall(res_stall)
  );

  always #1 clk = ~clk;

  function automatic void clear_shadow();
    for (int i = 0; i < SLOTS; i++) begin
      shadow_service[i] = '0;
      shadow_message[i] = '0;
      shadow_count[i]   = '0;
    end
  endfunction

  // Works out the result words for one accepted word and updates the shadow.
  function automatic void predict_table_update(cmd_word_t w);
    res_word_t        r;
    logic [SVC_W-1:0] svc;
    logic [MSG_W-1:0] mid;
    bit               placed;
    r = '0;
    if (w.command == CMD_DUMP) begin
      for (int i = 0; i < SLOTS; i++) begin
        r.status        = ST_DUMP;
        r.entry_index   = INDEX_W'(i);
        r.entry_service = shadow_service[i];
        r.entry_message = shadow_message[i];
        r.entry_count   = shadow_count[i];
        r.last          = (i == SLOTS - 1);
        pending_results.push_back(r);
      end
      clear_shadow();
      return;
    end
    svc             = w.service_word[SVC_W-1:0];
    mid             = w.message_word[MSG_ID_LSB +: MSG_W];
    r.entry_service = svc;
    r.entry_message = mid;
    r.last          = 1'b1;
    if (w.service_word[63:SVC_W] != '0 || mid == '0) begin
      r.status = ST_INVALID;
    end else begin
      r.status = ST_FULL;
      placed   = 1'b0;
      // slots fill from the bottom, so the first empty slot ends the search
      for (int i = 0; i < SLOTS && !placed; i++) begin
        if (shadow_service[i] == svc && shadow_message[i] == mid) begin
          shadow_count[i] = shadow_count[i] + 1'b1;
          r.status        = ST_COUNTED;
          r.entry_index   = INDEX_W'(i);
          r.entry_count   = shadow_count[i];
          placed          = 1'b1;
        end else if (shadow_message[i] == '0) begin
          shadow_service[i] = svc;
          shadow_message[i] = mid;
          shadow_count[i]   = 1;
          r.status          = ST_INSERTED;
          r.entry_index     = INDEX_W'(i);
          r.entry_count     = 1;
          placed            = 1'b1;
        end
      end
    end
    pending_results.push_back(r);
  endfunction

  function automatic cmd_word_t make_record(logic [63:0] svc_word, logic [7:0] mid,
                                            logic [23:0] low);
    cmd_word_t w;
    w.command      = CMD_RECORD;
    w.service_word = svc_word;
    w.message_word = {mid, low};
    return w;
  endfunction

  // Payload fields of a dump word are don't-care, so they carry noise.
  function automatic cmd_word_t make_dump();
    cmd_word_t w;
    w.command      = CMD_DUMP;
    w.service_word = {$urandom, $urandom};
    w.message_word = $urandom;
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  task automatic send_word(cmd_word_t w);
    int gap;
    @(negedge clk);
    cmd       <= w;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    predict_table_update(w);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      cmd_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_word(make_record(64'h0, 8'h01, 24'h000000));         // service id zero
    send_word(make_record(64'hFFFF, 8'hFF, 24'hFFFFFF));      // top service and id
    send_word(make_record(64'h0, 8'h01, 24'hABCDEF));         // low message bits ignored
    send_word(make_record(64'hFFFF, 8'hFF, 24'h000000));
    send_word(make_record(64'h1234, 8'h00, 24'h5A5A5A));      // message id zero
    send_word(make_record(64'h0001_0000, 8'h05, 24'h0));      // service bit 16
    send_word(make_record(64'h8000_0000_0000_0000, 8'h05, 24'h0)); // only high half
    send_word(make_record(64'h0000_0001_0000_0000, 8'h05, 24'h0));
    send_word(make_record({64{1'b1}}, 8'h00, 24'hFFFFFF));
    send_word(make_record(64'h00FF, 8'h01, 24'h0));           // same id, other service
    send_word(make_record(64'h0, 8'hFF, 24'h0));              // same service, other id
    send_word(make_dump());
    send_word(make_dump());                                   // table now empty
    send_word(make_record(64'h0, 8'h01, 24'h0));              // slot 0 reused after clear
    send_word(make_dump());
  endtask

  task automatic test_table_full();
    logic [SVC_W-1:0] top_svc;
    for (int i = 0; i < SLOTS; i++) begin
      top_svc = 16'($urandom);
      send_word(make_record({48'h0, top_svc}, 8'(i + 1), 24'($urandom)));
    end
    // hold the sender until the table has answered every insert
    wait_for_results();
    send_word(make_record({48'h0, 16'($urandom)}, 8'h80, 24'($urandom)));
    send_word(make_record({48'h0, ~top_svc}, 8'(SLOTS), 24'($urandom)));
    send_word(make_record({48'h0, top_svc}, 8'(SLOTS), 24'($urandom)));
    send_word(make_record(64'h1, 8'h00, 24'($urandom)));
    send_word(make_dump());
  endtask

  // Phases of records over a key pool, closed by a dump. Small pools build up
  // counts, large pools run the table into full.
  task automatic test_random_traffic(int item_goal);
    logic [SVC_W-1:0] pool_svc [48];
    logic [MSG_W-1:0] pool_mid [48];
    logic [63:0]      noise_svc;
    int               sent;
    int               pool_n;
    int               phase_len;
    int               pick;
    int               j;
    sent = 0;
    while (sent < item_goal) begin
      pool_n     = ($urandom_range(0, 1) == 0) ? 6 : 48;
      phase_len  = $urandom_range(15, 55);
      burst_mode = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < pool_n; k++) begin
        pool_svc[k] = 16'($urandom);
        pool_mid[k] = 8'($urandom_range(1, 255));
      end
      pool_svc[0] = 16'hFFFF;
      pool_mid[0] = 8'hFF;
      pool_svc[1] = 16'h0000;
      pool_mid[1] = 8'h01;
      for (int k = 0; k < phase_len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 9) begin
          case ($urandom_range(0, 2))
            0: begin
              noise_svc = {$urandom, $urandom};
              if (noise_svc[63:16] == '0) noise_svc[40] = 1'b1;
              send_word(make_record(noise_svc, 8'($urandom_range(0, 255)),
                                    24'($urandom)));
            end
            1: send_word(make_record({48'h0, 16'($urandom)}, 8'h00, 24'($urandom)));
            default: begin
              noise_svc = {$urandom | 32'h1, 16'h0, 16'($urandom)};
              send_word(make_record(noise_svc, 8'($urandom_range(1, 255)),
                                    24'($urandom)));
            end
          endcase
        end else if (pick < 11) begin
          send_word(make_dump());
        end else begin
          j = $urandom_range(0, pool_n - 1);
          send_word(make_record({48'h0, pool_svc[j]}, pool_mid[j], 24'($urandom)));
        end
      end
      send_word(make_dump());
      sent += phase_len + 1;
    end
    burst_mode = 1'b0;
  endtask

  function automatic void check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    res_word_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $time, res);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(res.status));
        check_field("entry_index", 32'(want.entry_index), 32'(res.entry_index));
        check_field("entry_service", 32'(want.entry_service), 32'(res.entry_service));
        check_field("entry_message", 32'(want.entry_message), 32'(res.entry_message));
        check_field("entry_count", want.entry_count, res.entry_count);
        check_field("last", 32'(want.last), 32'(res.last));
      end
    end
  end

  // Output stall: runs of free and stalled cycles, mostly short, a few long.
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if ($urandom_range(0, 99) < 55) begin
      res_stall  <= 1'b0;
      stall_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 6);
    end else begin
      res_stall  <= 1'b1;
      stall_hold <= ($urandom_range(0, 14) == 0) ? $urandom_range(20, 50)
                                                  : $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    clear_shadow();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_table_full();
    test_random_traffic(110);
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (pending_results.size() != 0) begin
        $display("%0t: %0d result words never arrived", $time, pending_results.size());
      end
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/ekct_pkg.sv
hdl/ekct_front.sv
hdl/ekct_queue.sv
hdl/ekct_engine.sv
hdl/event_key_counter_table_top.sv
test/tb_event_key_counter_table_top.sv
